@@ sv/circle_rasterizer_defines.svh @@
// ---------------------------------------------------------------------------
// Circle rasterizer assertion macros
// Shared helpers that keep the checks in the RTL short and uniform. They
// assume that the module has a clock named clk and a reset named rst.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_DEFINES_SVH
`define CIRCLE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRAST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRAST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/crast_pkg.sv @@
// ---------------------------------------------------------------------------
// Circle rasterizer package
// Types and fixed constants shared by the front, queue and back modules.
// ---------------------------------------------------------------------------
package crast_pkg;

  // Request modes.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Frame buffer geometry: 1024 pixels per line, 3 bytes per pixel.
  localparam int unsigned LINE_SHIFT = 10;

  // Pixel order within one step: quadrant code, the last one closes the step.
  localparam logic [1:0] PIX_FIRST = 2'd0;
  localparam logic [1:0] PIX_LAST  = 2'd3;

  // Step queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One step of the circle: center, current offsets, color and end mark.
  typedef struct packed {
    logic [11:0]        cx;
    logic [11:0]        cy;
    logic [11:0]        ox;
    logic signed [12:0] oy;
    logic [23:0]        color;
    logic               done;
  } step_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ sv/crast_ifs.sv @@
// ---------------------------------------------------------------------------
// Circle rasterizer channels
// Valid/ready interfaces for the request channel and the pixel channel.
// ---------------------------------------------------------------------------
interface crast_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [10:0] radius;
  logic [23:0] pixel_color;

  modport source (output valid, mode, center_x, center_y, radius, pixel_color,
                  input ready);
  modport sink   (input valid, mode, center_x, center_y, radius, pixel_color,
                  output ready);
endinterface

interface crast_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] pixel_x;
  logic signed [13:0] pixel_y;
  logic [31:0]        pixel_address;
  logic [23:0]        color_out;
  logic               on_screen;
  logic               last_of_step;
  logic               circle_done;

  modport source (output valid, pixel_x, pixel_y, pixel_address, color_out,
                  on_screen, last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, color_out,
                  on_screen, last_of_step, circle_done, output ready);
endinterface

@@ sv/crast_front.sv @@
// ---------------------------------------------------------------------------
// Circle rasterizer front end
// Accepts requests, keeps the midpoint state and queues one step per advance.
// ---------------------------------------------------------------------------
module crast_front (
  input  logic                     clk,
  input  logic                     rst,
  crast_in_if.sink                 in_req,
  input  crast_pkg::queue_status_t q_status,
  output logic                     q_push,
  output crast_pkg::step_t         q_data
);
  import crast_pkg::*;

  logic [11:0]        cur_center_x;
  logic [11:0]        cur_center_y;
  logic [23:0]        cur_color;
  logic [11:0]        offset_x;
  logic signed [12:0] offset_y;
  logic signed [15:0] decision_term;
  logic               active;

  logic               accept;
  logic signed [16:0] err_sum;
  logic [12:0]        dx_inc;
  logic signed [13:0] dy_dec;
  logic [15:0]        dxy_diff;
  logic signed [13:0] dy_next;
  logic [12:0]        dx_next;
  logic [15:0]        delta_next;
  logic               done;

  // A request is taken whenever the queue has room.
  assign in_req.ready = !q_status.full;
  assign accept       = in_req.valid && in_req.ready;

  // Midpoint decision: the signs of delta and of delta + dy decide the move.
  always_comb begin
    err_sum  = 17'(decision_term) + 17'(offset_y);
    dx_inc   = {1'b0, offset_x} + 13'd1;
    dy_dec   = 14'(offset_y) - 14'sd1;
    dxy_diff = 16'(dx_inc) - 16'(offset_y);
    priority if (decision_term < 0 && err_sum <= 0) begin
      dx_next    = dx_inc;
      dy_next    = 14'(offset_y);
      delta_next = 16'(decision_term) + {2'b00, dx_inc, 1'b1};
    end else if (decision_term > 0 && err_sum > 0) begin
      dx_next    = {1'b0, offset_x};
      dy_next    = dy_dec;
      delta_next = 16'(decision_term) - 16'(signed'({dy_dec, 1'b1}));
    end else begin
      dx_next    = dx_inc;
      dy_next    = dy_dec;
      delta_next = 16'(decision_term) + {dxy_diff[14:0], 1'b0};
    end
    done = dy_next[13];
  end

  // A step is queued for every advance taken while a circle runs.
  assign q_push       = accept && (in_req.mode == MODE_ADVANCE) && active;
  assign q_data.cx    = cur_center_x;
  assign q_data.cy    = cur_center_y;
  assign q_data.ox    = offset_x;
  assign q_data.oy    = offset_y;
  assign q_data.color = cur_color;
  assign q_data.done  = done;

  // State update on start and on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      cur_center_x  <= '0;
      cur_center_y  <= '0;
      cur_color     <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
      decision_term <= '0;
    end else if (accept) begin
      if (in_req.mode == MODE_START) begin
        active        <= 1'b1;
        cur_center_x  <= in_req.center_x;
        cur_center_y  <= in_req.center_y;
        cur_color     <= in_req.pixel_color;
        offset_x      <= '0;
        offset_y      <= signed'({2'b00, in_req.radius});
        decision_term <= signed'(16'd1 - {4'b0000, in_req.radius, 1'b0});
      end else if (active) begin
        offset_x      <= dx_next[11:0];
        offset_y      <= dy_next[12:0];
        decision_term <= signed'(delta_next);
        if (done) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

@@ sv/crast_queue.sv @@
// ---------------------------------------------------------------------------
// Circle rasterizer step queue
// Short FIFO of steps that decouples the front end from the pixel back end.
// ---------------------------------------------------------------------------
`include "circle_rasterizer_defines.svh"

module crast_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  crast_pkg::step_t         push_data,
  input  logic                     pop,
  output crast_pkg::step_t         head,
  output crast_pkg::queue_status_t status
);
  import crast_pkg::*;

  step_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // Step storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Checks on the queue and on both sides that drive it.
  `CRAST_ASSERT_NOW(a_no_push_full, push, !status.full, "step pushed into full queue")
  `CRAST_ASSERT_NOW(a_no_pop_empty, pop, !status.empty, "step popped from empty queue")
  `CRAST_ASSERT_NOW(a_count_range, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `CRAST_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

@@ sv/crast_back.sv @@
// ---------------------------------------------------------------------------
// Circle rasterizer back end
// Expands each queued step into four mirrored pixels with their addresses.
// ---------------------------------------------------------------------------
module crast_back #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              frame_base,
  input  crast_pkg::step_t         head,
  input  crast_pkg::queue_status_t q_status,
  output logic                     q_pop,
  crast_out_if.source              out_pix
);
  import crast_pkg::*;

  localparam logic [13:0] WIDTH_LIM  = 14'(SCREEN_WIDTH);
  localparam logic [13:0] HEIGHT_LIM = 14'(SCREEN_HEIGHT);

  logic [1:0]         pix_idx;
  logic               out_valid;
  logic               load;
  logic signed [13:0] px;
  logic signed [13:0] py;
  logic [31:0]        lin;
  logic [31:0]        addr;
  logic               visible;

  // A pixel loads if a step is queued and the output register is empty or drains.
  assign load  = (!out_valid || out_pix.ready) && !q_status.empty;
  assign q_pop = load && (pix_idx == PIX_LAST);

  // Mirrored coordinates: bit 1 flips x, bit 0 flips y.
  always_comb begin
    px = pix_idx[1] ? (signed'({2'b00, head.cx}) - signed'({2'b00, head.ox}))
                    : (signed'({2'b00, head.cx}) + signed'({2'b00, head.ox}));
    py = pix_idx[0] ? (signed'({2'b00, head.cy}) - 14'(head.oy))
                    : (signed'({2'b00, head.cy}) + 14'(head.oy));
    lin     = (32'(py) << LINE_SHIFT) + 32'(px);
    addr    = frame_base + lin + {lin[30:0], 1'b0};
    visible = !px[13] && !py[13] && (unsigned'(px) < WIDTH_LIM)
              && (unsigned'(py) < HEIGHT_LIM);
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pix_idx   <= PIX_FIRST;
    end else if (load) begin
      out_valid <= 1'b1;
      pix_idx   <= pix_idx + 1'b1;
    end else if (out_pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_pix.pixel_x       <= px;
      out_pix.pixel_y       <= py;
      out_pix.pixel_address <= addr;
      out_pix.color_out     <= head.color;
      out_pix.on_screen     <= visible;
      out_pix.last_of_step  <= (pix_idx == PIX_LAST);
      out_pix.circle_done   <= (pix_idx == PIX_LAST) && head.done;
    end
  end

  assign out_pix.valid = out_valid;

endmodule

@@ sv/circle_rasterizer.sv @@
// Circle rasterizer: midpoint circle generator with frame buffer addressing.
// Requests arrive on in_req (valid/ready). A start request (mode 0) loads the
// center, radius and color and produces no pixel. Each advance request
// (mode 1) produces four mirrored pixels on out_pix for the current offsets,
// then steps the decision term; the last pixel of the final step carries
// circle_done. An advance while no circle runs is taken and dropped.
// Each pixel carries its coordinates, byte address frame_base +
// (y*1024 + x)*3 modulo 2^32, color and an on-screen flag.
// frame_base is written through frame_base_we/frame_base_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// A step is registered in the step queue, then each of its four pixels in
// the output register, one after another on the single pixel port; a
// two-entry step queue lets starts and advances be taken back to back.
// Reset (rst, synchronous) clears the circle state, the queue and frame_base.
// When the receiver stalls, the output holds its pixel, the queue fills and
// in_req.ready drops.
// ---------------------------------------------------------------------------
// Circle rasterizer top level
// Front end, step queue and pixel back end with the frame base register.
// ---------------------------------------------------------------------------
module circle_rasterizer #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_base_we,
  input  logic [31:0] frame_base_wdata,
  crast_in_if.sink    in_req,
  crast_out_if.source out_pix
);
  import crast_pkg::*;

  logic [31:0]   frame_base;
  logic          q_push;
  logic          q_pop;
  step_t         q_data;
  step_t         q_head;
  queue_status_t q_status;

  // Frame base register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (frame_base_we) begin
      frame_base <= frame_base_wdata;
    end
  end

  crast_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_req   (in_req),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  crast_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  crast_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_base (frame_base),
    .head       (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_pix    (out_pix)
  );

endmodule
